// ===== rtl/core/smr_pkg.sv =====
// Shared types and constants for the stack machine.
// Command codes, queue sizing and the queued command word layout.
`default_nettype none

package smr_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VALUE_W = 32;
    localparam int PUSH_W = 31;
    localparam int REQ_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [REQ_W-1:0] CMD_POP   = 3'd1;
    localparam logic [REQ_W-1:0] CMD_SWAP  = 3'd2;
    localparam logic [REQ_W-1:0] CMD_ADD   = 3'd3;
    localparam logic [REQ_W-1:0] CMD_ROLL  = 3'd4;
    localparam logic [REQ_W-1:0] CMD_PRINT = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]  op;
        logic [PUSH_W-1:0] value;
    } smr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/smr_front.sv =====
// Front end: accepts command words and drops unused command codes.
// Depends on smr_pkg; feeds smr_queue.
`default_nettype none

module smr_front
(
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [smr_pkg::REQ_W-1:0]  req_type,
    input  wire logic [smr_pkg::PUSH_W-1:0] push_value,
    input  wire logic                       queue_full,
    output logic                            queue_push,
    output smr_pkg::smr_cmd_t               queue_word
);
    import smr_pkg::*;

    logic accept;
    logic known;

    always_comb
    begin
        case (req_type)
            CMD_PUSH, CMD_POP, CMD_SWAP, CMD_ADD, CMD_ROLL, CMD_PRINT:
                known = 1'b1;
            default:
                known = 1'b0;
        endcase
    end

    assign in_stall         = queue_full;
    assign accept           = in_valid && !queue_full;
    assign queue_push       = accept && known;
    assign queue_word.op    = req_type;
    assign queue_word.value = push_value;

endmodule

`default_nettype wire

// ===== rtl/core/smr_queue.sv =====
// Short command queue between the front end and the execution unit.
// Depends on smr_pkg for the command word and queue sizing.
`default_nettype none

module smr_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire smr_pkg::smr_cmd_t push_word,
    output logic                   full,
    output logic                   head_valid,
    output smr_pkg::smr_cmd_t      head_word,
    input  wire logic              pop
);
    import smr_pkg::*;

    smr_cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   fill_reg;
    logic [QUEUE_CW-1:0]   fill_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (fill_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_word  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/smr_back.sv =====
// Execution unit: stack memory, entry count, overflow flag and print output.
// Depends on smr_pkg; takes commands from smr_queue.
`default_nettype none

module smr_back
#(
    parameter int STACK_DEPTH = smr_pkg::STACK_DEPTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    input  wire smr_pkg::smr_cmd_t            cmd_word,
    output logic                              cmd_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [smr_pkg::VALUE_W-1:0] entry_value,
    output logic                              last_entry,
    output logic                              stack_empty,
    output logic                              overflow_seen
);
    import smr_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SWAP_B  = 4'd1;
    localparam logic [3:0] ST_SWAP_W  = 4'd2;
    localparam logic [3:0] ST_SWAP_W2 = 4'd3;
    localparam logic [3:0] ST_ADD_B   = 4'd4;
    localparam logic [3:0] ST_ADD_W   = 4'd5;
    localparam logic [3:0] ST_ROLL_N  = 4'd6;
    localparam logic [3:0] ST_ROLL_M  = 4'd7;
    localparam logic [3:0] ST_ROLL_S  = 4'd8;
    localparam logic [3:0] ST_ROLL_E  = 4'd9;
    localparam logic [3:0] ST_PRT     = 4'd10;
    localparam logic [3:0] ST_PRT_E   = 4'd11;

    logic [VALUE_W-1:0] mem [STACK_DEPTH];
    logic [VALUE_W-1:0] rd_reg;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [VALUE_W-1:0] tmp_reg;
    logic [VALUE_W-1:0] tmp_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic [AW-1:0]      dest_reg;
    logic [AW-1:0]      dest_next;
    logic [CW-1:0]      left_reg;
    logic [CW-1:0]      left_next;
    logic               pend_reg;
    logic               pend_next;
    logic               pend_last_reg;
    logic               pend_last_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [VALUE_W-1:0] out_value_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               out_empty_reg;
    logic               out_empty_next;
    logic               out_ovf_reg;
    logic               out_ovf_next;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [VALUE_W-1:0] mem_wd;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;

    logic [CW-1:0]      count_m1;
    logic [CW-1:0]      count_m2;
    logic [AW-1:0]      top_idx;
    logic [AW-1:0]      sec_idx;
    logic [AW-1:0]      idx_m1;
    logic [CW-1:0]      dest_full;
    logic               roll_ok;
    logic               out_free;
    logic               out_load;
    logic               issue;

    assign count_m1  = count_reg - CW'(1);
    assign count_m2  = count_reg - CW'(2);
    assign top_idx   = count_m1[AW-1:0];
    assign sec_idx   = count_m2[AW-1:0];
    assign idx_m1    = idx_reg - AW'(1);
    assign dest_full = count_reg - rd_reg[CW-1:0];
    assign roll_ok   = !rd_reg[VALUE_W-1]
                       && (rd_reg[VALUE_W-2:0] >= (VALUE_W-1)'(2))
                       && (count_reg >= CW'(2))
                       && (rd_reg[VALUE_W-2:0] <= (VALUE_W-1)'(count_reg));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        tmp_next       = tmp_reg;
        idx_next       = idx_reg;
        dest_next      = dest_reg;
        left_next      = left_reg;
        pend_last_next = pend_last_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_wa         = top_idx;
        mem_wd         = rd_reg;
        mem_re         = 1'b0;
        mem_ra         = top_idx;
        cmd_pop        = 1'b0;
        out_load       = 1'b0;
        issue          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    case (cmd_word.op)
                        CMD_PUSH:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = count_reg[AW-1:0];
                                mem_wd     = {1'b0, cmd_word.value};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_m1;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_SWAP_B;
                            end
                        end
                        CMD_ADD:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_ADD_B;
                            end
                        end
                        CMD_ROLL:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                count_next = count_m1;
                                state_next = ST_ROLL_N;
                            end
                        end
                        CMD_PRINT:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_PRT_E;
                            end
                            else
                            begin
                                idx_next   = top_idx;
                                left_next  = count_reg;
                                state_next = ST_PRT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWAP_B:
            begin
                tmp_next   = rd_reg;
                mem_re     = 1'b1;
                mem_ra     = sec_idx;
                state_next = ST_SWAP_W;
            end
            ST_SWAP_W:
            begin
                mem_we     = 1'b1;
                mem_wa     = top_idx;
                mem_wd     = rd_reg;
                state_next = ST_SWAP_W2;
            end
            ST_SWAP_W2:
            begin
                mem_we     = 1'b1;
                mem_wa     = sec_idx;
                mem_wd     = tmp_reg;
                state_next = ST_IDLE;
            end
            ST_ADD_B:
            begin
                tmp_next   = rd_reg;
                mem_re     = 1'b1;
                mem_ra     = sec_idx;
                state_next = ST_ADD_W;
            end
            ST_ADD_W:
            begin
                mem_we     = 1'b1;
                mem_wa     = sec_idx;
                mem_wd     = tmp_reg + rd_reg;
                count_next = count_m1;
                state_next = ST_IDLE;
            end
            ST_ROLL_N:
            begin
                if (roll_ok)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = top_idx;
                    idx_next   = top_idx;
                    dest_next  = dest_full[AW-1:0];
                    state_next = ST_ROLL_M;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROLL_M:
            begin
                tmp_next   = rd_reg;
                mem_re     = 1'b1;
                mem_ra     = idx_m1;
                state_next = ST_ROLL_S;
            end
            ST_ROLL_S:
            begin
                mem_we   = 1'b1;
                mem_wa   = idx_reg;
                mem_wd   = rd_reg;
                idx_next = idx_m1;
                if (idx_m1 > dest_reg)
                begin
                    mem_re = 1'b1;
                    mem_ra = idx_m1 - AW'(1);
                end
                else
                begin
                    state_next = ST_ROLL_E;
                end
            end
            ST_ROLL_E:
            begin
                mem_we     = 1'b1;
                mem_wa     = dest_reg;
                mem_wd     = tmp_reg;
                state_next = ST_IDLE;
            end
            ST_PRT:
            begin
                out_load = pend_reg && out_free;
                issue    = (left_reg != '0) && (!pend_reg || out_load);
                if (out_load)
                begin
                    out_value_next = rd_reg;
                    out_last_next  = pend_last_reg;
                    out_empty_next = 1'b0;
                    out_ovf_next   = ovf_reg;
                end
                if (issue)
                begin
                    mem_re         = 1'b1;
                    mem_ra         = idx_reg;
                    idx_next       = idx_m1;
                    left_next      = left_reg - CW'(1);
                    pend_last_next = (left_reg == CW'(1));
                end
                if ((left_reg == '0) && (!pend_reg || out_load))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRT_E:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        pend_next = issue || (pend_reg && !out_load);

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg       <= tmp_next;
        idx_reg       <= idx_next;
        dest_reg      <= dest_next;
        left_reg      <= left_next;
        pend_last_reg <= pend_last_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_value   = out_value_reg;
    assign last_entry    = out_last_reg;
    assign stack_empty   = out_empty_reg;
    assign overflow_seen = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/core/stack_machine_push_pop_swap_add_roll.sv =====
// Stack machine with push, pop, swap, add, roll and print commands.
// A front end classifies each command word into a short queue; the execution unit
// drains it against a single-port-style stack memory (one write, one registered read per
// cycle). Push and pop finish in the idle state; add and swap read both operands first;
// roll pops its count, then rotates entries one at a time or only drops the count; print
// reads entries top down (one empty word on an empty stack), all paced by that memory port.
// Printed words leave via an output register, so other commands run on while the last
// one waits on out_stall. The input side stalls only when the command queue is full.
// Depends on smr_pkg, smr_front, smr_queue and smr_back.
`default_nettype none

module stack_machine_push_pop_swap_add_roll
#(
    parameter int STACK_DEPTH = smr_pkg::STACK_DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [smr_pkg::REQ_W-1:0]     req_type,
    input  wire logic [smr_pkg::PUSH_W-1:0]    push_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [smr_pkg::VALUE_W-1:0] entry_value,
    output logic                               last_entry,
    output logic                               stack_empty,
    output logic                               overflow_seen
);
    import smr_pkg::*;

    logic     queue_full;
    logic     queue_push;
    smr_cmd_t queue_word;
    logic     head_valid;
    smr_cmd_t head_word;
    logic     head_pop;

    smr_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .push_value (push_value),
        .queue_full (queue_full),
        .queue_push (queue_push),
        .queue_word (queue_word)
    );

    smr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_word  (queue_word),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (head_pop)
    );

    smr_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (head_valid),
        .cmd_word      (head_word),
        .cmd_pop       (head_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .entry_value   (entry_value),
        .last_entry    (last_entry),
        .stack_empty   (stack_empty),
        .overflow_seen (overflow_seen)
    );

endmodule

`default_nettype wire
